FILE: hdl/thermal_elastic_xs_correction_assert.svh
// assertion macros shared by the checker of the thermal elastic correction block
`ifndef THERMAL_ELASTIC_XS_CORRECTION_ASSERT_SVH
`define THERMAL_ELASTIC_XS_CORRECTION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TECX_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TECX_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tecx_pkg.sv
// types, constants and helpers of the thermal elastic correction block
package tecx_pkg;

    // field widths
    localparam int XS_W    = 32;
    localparam int FRAC_W  = 17;
    localparam int TV_W    = 20;
    localparam int TIDX_W  = 6;
    localparam int E_W     = 45;
    localparam int AW_W    = 24;
    localparam int KT_W    = 32;

    // internal widths
    localparam int A2Q_W   = 25;   // a2 in Q.16, bounded in the thermal region
    localparam int AQ_W    = 17;   // sqrt of a2 in Q.16 below the wide threshold
    localparam int DVD_W   = 57;   // elastic correction dividend
    localparam int DVS_W   = 26;   // elastic correction divisor
    localparam int Q_W     = 32;   // elastic correction quotient

    localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
    localparam logic [A2Q_W-1:0]  A2Q_WIDE  = 25'd262144;  // a2 = 4.0
    localparam logic [DVS_W-1:0]  A2Q_HALF  = 26'd32768;   // 0.5
    localparam logic [8:0]        THERM_LIM = 9'd500;
    localparam logic [4:0]        TBL_SCALE = 5'd25;

    // item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ATOM_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KT          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_URR         = 2'd2;

    localparam logic [AW_W-1:0] ATOM_WEIGHT_RST = 24'd32768;
    localparam logic [KT_W-1:0] KT_RST          = 32'd25300;

    // what the back does with an item
    typedef enum logic [2:0] {
        K_LOAD,
        K_SKIP,
        K_PLAIN,
        K_NARROW,
        K_WIDE
    } t_kind;

    typedef struct packed {
        logic [AW_W-1:0] atom_weight;
        logic [KT_W-1:0] kt;
        logic            urr;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [XS_W-1:0]   abs_xs;
        logic [XS_W-1:0]   el_xs;
        logic [XS_W-1:0]   inel_xs;
        logic [A2Q_W-1:0]  a2q;
        logic [TIDX_W-1:0] tbl_index;
        logic [TV_W-1:0]   tbl_value;
    } t_work;

    typedef struct packed {
        logic [XS_W-1:0] abs_xs;
        logic [XS_W-1:0] el_xs;
        logic [XS_W-1:0] inel_xs;
        logic            skipped;
        logic            adjusted;
    } t_result;

    // a fraction above one counts as one
    function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] f);
        return (f > FRAC_ONE) ? FRAC_ONE : f;
    endfunction

endpackage

FILE: hdl/tecx_channels.sv
// item, result and configuration channels of the thermal elastic correction block
interface tecx_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [5:0]  table_index;
    logic [19:0] table_value;
    logic [44:0] energy;
    logic [31:0] abs_low;
    logic [31:0] abs_high;
    logic [16:0] frac_abs;
    logic [31:0] el_low;
    logic [31:0] el_high;
    logic [31:0] inel_low;
    logic [31:0] inel_high;
    logic [16:0] frac_scatter;

    modport source (
        output valid, opcode, table_index, table_value, energy, abs_low, abs_high,
               frac_abs, el_low, el_high, inel_low, inel_high, frac_scatter,
        input  ready
    );
    modport sink (
        input  valid, opcode, table_index, table_value, energy, abs_low, abs_high,
               frac_abs, el_low, el_high, inel_low, inel_high, frac_scatter,
        output ready
    );
endinterface

interface tecx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] absorption_xs;
    logic [31:0] elastic_xs;
    logic [31:0] inelastic_xs;
    logic        skipped;
    logic        adjusted;

    modport source (
        output valid, absorption_xs, elastic_xs, inelastic_xs, skipped, adjusted,
        input  ready
    );
    modport sink (
        input  valid, absorption_xs, elastic_xs, inelastic_xs, skipped, adjusted,
        output ready
    );
endinterface

interface tecx_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/tecx_front.sv
// front: accepts items, interpolates, classifies and divides out a2
module tecx_front #(
    parameter int TABLE_ENTRIES = 51
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tecx_pkg::t_cfg   i_cfg,
    tecx_in_if.sink          i_item,
    input  logic             i_full,
    output logic             o_push,
    output tecx_pkg::t_work  o_work
);
    import tecx_pkg::*;

    localparam int DS = A2Q_W;  // one quotient bit per divider stage

    logic              en;
    logic              acc;
    logic [FRAC_W-1:0] f_abs;
    logic [FRAC_W-1:0] f_sc;
    t_kind             kind0;

    // stage 1: products
    logic              r1_v;
    t_kind             r1_kind;
    logic [TIDX_W-1:0] r1_idx;
    logic [TV_W-1:0]   r1_val;
    logic [48:0]       r1_abs_lo, r1_abs_hi, r1_el_lo, r1_el_hi, r1_in_lo, r1_in_hi;
    logic [46:0]       r1_pl;
    logic [45:0]       r1_ph;
    logic [40:0]       r1_lim;

    // stage 2: sums
    logic              r2_v;
    t_kind             r2_kind;
    logic [TIDX_W-1:0] r2_idx;
    logic [TV_W-1:0]   r2_val;
    logic [XS_W-1:0]   r2_abs, r2_el, r2_inel;
    logic [68:0]       r2_p;
    logic [55:0]       r2_lim;

    // a2 divider stages
    logic              r_dv   [0:DS];
    t_work             r_dw   [0:DS];
    logic [31:0]       r_drem [0:DS];
    logic [DS-1:0]     r_dql  [0:DS];
    logic [31:0]       n_drem [1:DS];
    logic [DS-1:0]     n_dql  [1:DS];

    logic              thermal;
    t_work             work0;
    logic [69:0]       num0;

    // global advance: the last stage drains into the queue
    assign en           = !r_dv[DS] || !i_full;
    assign i_item.ready = en;
    assign acc          = i_item.valid && en;

    assign f_abs = clamp_frac(i_item.frac_abs);
    assign f_sc  = clamp_frac(i_item.frac_scatter);

    // first classification
    always_comb begin
        if (!i_item.opcode) begin
            kind0 = (32'(i_item.table_index) < TABLE_ENTRIES) ? K_LOAD : K_SKIP;
        end else begin
            kind0 = i_cfg.urr ? K_SKIP : K_PLAIN;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            for (int k = 0; k <= DS; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r1_v    <= acc;
            r2_v    <= r1_v;
            r_dv[0] <= r2_v;
            for (int k = 1; k <= DS; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind   <= kind0;
            r1_idx    <= i_item.table_index;
            r1_val    <= i_item.table_value;
            r1_abs_lo <= 49'(i_item.abs_low) * 49'(FRAC_ONE - f_abs);
            r1_abs_hi <= 49'(i_item.abs_high) * 49'(f_abs);
            r1_el_lo  <= 49'(i_item.el_low) * 49'(FRAC_ONE - f_sc);
            r1_el_hi  <= 49'(i_item.el_high) * 49'(f_sc);
            r1_in_lo  <= 49'(i_item.inel_low) * 49'(FRAC_ONE - f_sc);
            r1_in_hi  <= 49'(i_item.inel_high) * 49'(f_sc);
            r1_pl     <= 47'(i_cfg.atom_weight) * 47'(i_item.energy[22:0]);
            r1_ph     <= 46'(i_cfg.atom_weight) * 46'(i_item.energy[44:23]);
            r1_lim    <= 41'(i_cfg.kt) * 41'(THERM_LIM);
        end
    end

    // stage 2 payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_kind <= r1_kind;
            r2_idx  <= r1_idx;
            r2_val  <= r1_val;
            r2_abs  <= 32'((50'(r1_abs_lo) + 50'(r1_abs_hi)) >> 16);
            r2_el   <= 32'((50'(r1_el_lo) + 50'(r1_el_hi)) >> 16);
            r2_inel <= 32'((50'(r1_in_lo) + 50'(r1_in_hi)) >> 16);
            r2_p    <= 69'(r1_pl) + (69'(r1_ph) << 23);
            r2_lim  <= 56'(r1_lim) << 15;
        end
    end

    // thermal region test and divider load
    always_comb begin
        thermal = (r2_kind == K_PLAIN) && (i_cfg.kt != '0) &&
                  ((i_cfg.atom_weight == '0) || (r2_p <= 69'(r2_lim)));
        num0            = {r2_p, 1'b0};
        work0.kind      = thermal ? K_NARROW : r2_kind;
        work0.abs_xs    = r2_abs;
        work0.el_xs     = r2_el;
        work0.inel_xs   = r2_inel;
        work0.a2q       = '0;
        work0.tbl_index = r2_idx;
        work0.tbl_value = r2_val;
    end

    // restoring division by kT, one bit a stage
    always_comb begin
        logic [32:0] t;
        logic        ge;
        t  = '0;
        ge = 1'b0;
        for (int k = 1; k <= DS; k++) begin
            t        = {r_drem[k-1], r_dql[k-1][DS-1]};
            ge       = (t >= {1'b0, i_cfg.kt});
            n_drem[k] = ge ? 32'(t - {1'b0, i_cfg.kt}) : t[31:0];
            n_dql[k]  = {r_dql[k-1][DS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dw[0]   <= work0;
            r_drem[0] <= num0[56:25];
            r_dql[0]  <= num0[DS-1:0];
            for (int k = 1; k <= DS; k++) begin
                r_dw[k]   <= r_dw[k-1];
                r_drem[k] <= n_drem[k];
                r_dql[k]  <= n_dql[k];
            end
        end
    end

    // final classification on a2
    always_comb begin
        o_work     = r_dw[DS];
        o_work.a2q = r_dql[DS];
        if (r_dw[DS].kind == K_NARROW && r_dql[DS] >= A2Q_WIDE) begin
            o_work.kind = K_WIDE;
        end
    end

    assign o_push = r_dv[DS] && !i_full;

endmodule

FILE: hdl/tecx_queue.sv
// short item queue between the front and the back
module tecx_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tecx_pkg::t_work  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output tecx_pkg::t_work  o_data,
    output logic             o_empty
);
    import tecx_pkg::*;

    t_work               r_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: hdl/tecx_back.sv
// back: square root, table lookup, shared correction divider and result register
module tecx_back #(
    parameter int TABLE_ENTRIES = 51
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tecx_pkg::t_work  i_work,
    input  logic             i_empty,
    output logic             o_pop,
    tecx_out_if.source       o_res
);
    import tecx_pkg::*;

    localparam int SQ       = AQ_W;
    localparam int QS       = Q_W;
    localparam int AW       = $clog2(TABLE_ENTRIES);
    localparam int LAST_IDX = TABLE_ENTRIES - 1;

    logic en;

    // sqrt stages
    logic          r_sv    [0:SQ];
    t_work         r_sw    [0:SQ];
    logic [18:0]   r_srem  [0:SQ];
    logic [SQ-1:0] r_sroot [0:SQ];
    logic [18:0]   n_srem  [1:SQ];
    logic [SQ-1:0] n_sroot [1:SQ];

    // table lookup
    logic [TV_W-1:0] r_tbl [0:TABLE_ENTRIES-1];
    logic [21:0]     b;
    logic [5:0]      bi;
    logic [6:0]      bi1;
    logic [AW-1:0]   addr0, addr1;

    // stage m: table data and products
    logic              r_mv;
    t_work             r_mw;
    logic [TV_W-1:0]   r_t0, r_t1;
    logic [15:0]       r_bf;
    logic [48:0]       r_num_n;
    logic [DVD_W-1:0]  r_num_w;
    logic [DVS_W-1:0]  r_dvs_w;

    // stage p: table lerp products
    logic              r_pv;
    t_work             r_pw;
    logic [36:0]       r_p_lo, r_p_hi;
    logic [48:0]       r_p_num_n;
    logic [DVD_W-1:0]  r_p_num_w;
    logic [DVS_W-1:0]  r_p_dvs_w;

    // stage q: interpolated table value
    logic              r_qv;
    t_work             r_qw;
    logic [TV_W-1:0]   r_t;
    logic [48:0]       r_q_num_n;
    logic [DVD_W-1:0]  r_q_num_w;
    logic [DVS_W-1:0]  r_q_dvs_w;

    // shared divider stages
    logic              r_dv   [0:QS];
    t_work             r_dw   [0:QS];
    logic [DVS_W-1:0]  r_drem [0:QS];
    logic [QS-1:0]     r_dql  [0:QS];
    logic [DVS_W-1:0]  r_ddvs [0:QS];
    logic              r_dsat [0:QS];
    logic              r_dnz  [0:QS];
    logic [DVS_W-1:0]  n_drem [1:QS];
    logic [QS-1:0]     n_dql  [1:QS];

    logic [DVD_W-1:0]  dvd0;
    logic [DVS_W-1:0]  dvs0;
    logic              sat0;

    logic              r_out_valid;
    t_result           r_res;
    t_result           n_res;

    // global advance: the result register drains to the sink
    assign en    = !r_out_valid || o_res.ready;
    assign o_pop = en && !i_empty;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQ; k++) begin
                r_sv[k] <= 1'b0;
            end
            r_mv <= 1'b0;
            r_pv <= 1'b0;
            r_qv <= 1'b0;
            for (int k = 0; k <= QS; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sv[0] <= !i_empty;
            for (int k = 1; k <= SQ; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_mv    <= r_sv[SQ];
            r_pv    <= r_mv;
            r_qv    <= r_pv;
            r_dv[0] <= r_qv;
            for (int k = 1; k <= QS; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_out_valid <= r_dv[QS];
        end
    end

    // digit-by-digit square root of a2 in Q.32
    always_comb begin
        logic [33:0] v;
        logic [20:0] r;
        logic [18:0] trial;
        logic        ge;
        v     = '0;
        r     = '0;
        trial = '0;
        ge    = 1'b0;
        for (int k = 1; k <= SQ; k++) begin
            v          = {r_sw[k-1].a2q[17:0], 16'b0};
            r          = {r_srem[k-1], v[33-2*(k-1) -: 2]};
            trial      = {r_sroot[k-1], 2'b01};
            ge         = (r >= 21'(trial));
            n_srem[k]  = ge ? 19'(r - 21'(trial)) : r[18:0];
            n_sroot[k] = {r_sroot[k-1][SQ-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sw[0]    <= i_work;
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            for (int k = 1; k <= SQ; k++) begin
                r_sw[k]    <= r_sw[k-1];
                r_srem[k]  <= n_srem[k];
                r_sroot[k] <= n_sroot[k];
            end
        end
    end

    // table position 25*a
    always_comb begin
        b     = 22'(r_sroot[SQ]) * 22'(TBL_SCALE);
        bi    = b[21:16];
        bi1   = {1'b0, bi} + 7'd1;
        addr0 = (int'(bi) >= LAST_IDX) ? AW'(LAST_IDX) : AW'(bi);
        addr1 = (int'(bi1) >= LAST_IDX) ? AW'(LAST_IDX) : AW'(bi1);
    end

    // table memory: loads write at the stage where computes read, keeping item order
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_sv[SQ] && r_sw[SQ].kind == K_LOAD) begin
                r_tbl[AW'(r_sw[SQ].tbl_index)] <= r_sw[SQ].tbl_value;
            end
            r_t0 <= r_tbl[addr0];
            r_t1 <= r_tbl[addr1];
        end
    end

    // stage m payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mw    <= r_sw[SQ];
            r_bf    <= b[15:0];
            r_num_n <= 49'(r_sw[SQ].el_xs) * 49'(r_sroot[SQ]);
            r_num_w <= 57'(r_sw[SQ].el_xs) * 57'(r_sw[SQ].a2q);
            r_dvs_w <= 26'(r_sw[SQ].a2q) + A2Q_HALF;
        end
    end

    // stage p payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pw      <= r_mw;
            r_p_lo    <= 37'(r_t0) * 37'(FRAC_ONE - 17'(r_bf));
            r_p_hi    <= 37'(r_t1) * 37'(r_bf);
            r_p_num_n <= r_num_n;
            r_p_num_w <= r_num_w;
            r_p_dvs_w <= r_dvs_w;
        end
    end

    // stage q payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qw      <= r_pw;
            r_t       <= 20'((38'(r_p_lo) + 38'(r_p_hi)) >> 16);
            r_q_num_n <= r_p_num_n;
            r_q_num_w <= r_p_num_w;
            r_q_dvs_w <= r_p_dvs_w;
        end
    end

    // divider operands by branch
    always_comb begin
        if (r_qw.kind == K_WIDE) begin
            dvd0 = r_q_num_w;
            dvs0 = r_q_dvs_w;
            sat0 = 1'b0;
        end else begin
            dvd0 = 57'(r_q_num_n);
            dvs0 = 26'(r_t);
            sat0 = (20'(r_q_num_n[48:32]) >= r_t);
        end
    end

    // restoring division, one quotient bit a stage
    always_comb begin
        logic [DVS_W:0] t;
        logic           ge;
        t  = '0;
        ge = 1'b0;
        for (int k = 1; k <= QS; k++) begin
            t         = {r_drem[k-1], r_dql[k-1][QS-1]};
            ge        = (t >= {1'b0, r_ddvs[k-1]});
            n_drem[k] = ge ? DVS_W'(t - {1'b0, r_ddvs[k-1]}) : t[DVS_W-1:0];
            n_dql[k]  = {r_dql[k-1][QS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dw[0]   <= r_qw;
            r_drem[0] <= DVS_W'(dvd0[DVD_W-1:QS]);
            r_dql[0]  <= dvd0[QS-1:0];
            r_ddvs[0] <= dvs0;
            r_dsat[0] <= sat0;
            r_dnz[0]  <= (r_q_num_n != '0);
            for (int k = 1; k <= QS; k++) begin
                r_dw[k]   <= r_dw[k-1];
                r_drem[k] <= n_drem[k];
                r_dql[k]  <= n_dql[k];
                r_ddvs[k] <= r_ddvs[k-1];
                r_dsat[k] <= r_dsat[k-1];
                r_dnz[k]  <= r_dnz[k-1];
            end
        end
    end

    // result assembly
    always_comb begin
        n_res = '0;
        unique case (r_dw[QS].kind)
            K_LOAD, K_SKIP: begin
                n_res.skipped = 1'b1;
            end
            K_PLAIN: begin
                n_res.abs_xs  = r_dw[QS].abs_xs;
                n_res.el_xs   = r_dw[QS].el_xs;
                n_res.inel_xs = r_dw[QS].inel_xs;
            end
            K_NARROW: begin
                n_res.abs_xs   = r_dw[QS].abs_xs;
                n_res.inel_xs  = r_dw[QS].inel_xs;
                n_res.adjusted = 1'b1;
                if (r_dsat[QS]) begin
                    n_res.el_xs = r_dnz[QS] ? '1 : '0;
                end else begin
                    n_res.el_xs = r_dql[QS];
                end
            end
            K_WIDE: begin
                n_res.abs_xs   = r_dw[QS].abs_xs;
                n_res.el_xs    = r_dql[QS];
                n_res.inel_xs  = r_dw[QS].inel_xs;
                n_res.adjusted = 1'b1;
            end
            default: begin
                n_res.skipped = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.absorption_xs = r_res.abs_xs;
    assign o_res.elastic_xs    = r_res.el_xs;
    assign o_res.inelastic_xs  = r_res.inel_xs;
    assign o_res.skipped       = r_res.skipped;
    assign o_res.adjusted      = r_res.adjusted;

endmodule

FILE: hdl/thermal_elastic_xs_correction.sv
// Throughput: one item per cycle while the result sink takes results; set by
// the bit-per-stage a2 divider, square root and correction divider, each fully
// pipelined.
// Reset: synchronous active low; clears valid state and loads configuration
// defaults; the thermal table holds no defined value until loaded.
// Configuration writes are accepted every cycle.
module thermal_elastic_xs_correction #(
    parameter int TABLE_ENTRIES = 51
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tecx_in_if.sink   i_item,
    tecx_out_if.source o_result,
    tecx_cfg_if.sink  i_cfg
);
    import tecx_pkg::*;

    logic  r_urr;
    logic [AW_W-1:0] r_atom_weight;
    logic [KT_W-1:0] r_kt;
    t_cfg  cfg;
    logic  q_push, q_full, q_pop, q_empty;
    t_work q_in, q_out;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atom_weight <= ATOM_WEIGHT_RST;
            r_kt          <= KT_RST;
            r_urr         <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ATOM_WEIGHT: r_atom_weight <= i_cfg.data[AW_W-1:0];
                REG_KT:          r_kt          <= i_cfg.data;
                REG_URR:         r_urr         <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.atom_weight = r_atom_weight;
    assign cfg.kt          = r_kt;
    assign cfg.urr         = r_urr;

    // front, queue and back
    tecx_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg),
        .i_item (i_item),
        .i_full (q_full),
        .o_push (q_push),
        .o_work (q_in)
    );

    tecx_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_empty(q_empty)
    );

    tecx_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_work (q_out),
        .i_empty(q_empty),
        .o_pop  (q_pop),
        .o_res  (o_result)
    );

endmodule

FILE: hdl/tecx_checker.sv
// port-level checker of the thermal elastic correction block, bound to the top level
`include "thermal_elastic_xs_correction_assert.svh"

module tecx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_abs,
    input logic [31:0] i_el,
    input logic [31:0] i_inel,
    input logic        i_skipped,
    input logic        i_adjusted
);
    logic [7:0] r_pending;
    logic [7:0] n_pending;
    logic       in_acc;
    logic       out_acc;

    // items taken but not yet answered
    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (in_acc && !out_acc) begin
            n_pending = r_pending + 8'd1;
        end else if (!in_acc && out_acc) begin
            n_pending = r_pending - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `TECX_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `TECX_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_abs) && $stable(i_el) && $stable(i_inel) && $stable(i_skipped) && $stable(i_adjusted), "result changed while stalled")
    `TECX_ASSERT_IMP(a_skip_zero, i_clk, i_rst_n, i_out_valid && i_skipped, i_abs == '0 && i_el == '0 && i_inel == '0 && !i_adjusted, "skipped result carries data")
    `TECX_ASSERT_IMP(a_no_orphan, i_clk, i_rst_n, i_out_valid, r_pending != '0, "result without an item")

endmodule

bind thermal_elastic_xs_correction tecx_checker u_tecx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_item.valid),
    .i_in_ready (i_item.ready),
    .i_out_valid(o_result.valid),
    .i_out_ready(o_result.ready),
    .i_abs      (o_result.absorption_xs),
    .i_el       (o_result.elastic_xs),
    .i_inel     (o_result.inelastic_xs),
    .i_skipped  (o_result.skipped),
    .i_adjusted (o_result.adjusted)
);
